>>> sv/remote_drive_controller_top_macros.svh
// Assertion macros for the remote drive controller.
`ifndef REMOTE_DRIVE_CONTROLLER_TOP_MACROS_SVH
`define REMOTE_DRIVE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rdc assertion failed");

// Next-cycle implication, checked outside reset.
`define RDC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rdc assertion failed");

`endif

>>> sv/rdc_pkg.sv
// Shared types and constants for the remote drive controller.
`timescale 1ns / 1ps
package rdc_pkg;

	localparam logic [3:0] RESET_PERIOD = 4'd11;
	localparam logic [2:0] RESET_BOOST  = 3'd2;
	localparam logic [3:0] AUTO_SPEED   = 4'd3;
	localparam logic [3:0] SPEED_MAX    = 4'd15;

	localparam logic [7:0] TURN_LEFT  = 8'd1;
	localparam logic [7:0] TURN_RIGHT = 8'd2;
	localparam logic [7:0] LEVEL_RESET = 8'd5;
	localparam logic [7:0] LEVEL_STOP_LO = 8'd5;
	localparam logic [7:0] LEVEL_STOP_HI = 8'd6;

	// register indexes on the configuration port
	localparam logic REG_PWM_PERIOD = 1'b0;
	localparam logic REG_TURN_BOOST = 1'b1;

	typedef struct packed {
		logic la;
		logic lb;
		logic ra;
		logic rb;
	} bridge_t;

	typedef struct packed {
		logic       hit;
		logic [3:0] speed;
	} speed_lut_t;

	function automatic speed_lut_t speed_lookup(input logic [7:0] level);
		speed_lut_t r;
		r.hit = 1'b1;
		r.speed = 4'd0;
		case (level)
			8'd1, 8'd10: r.speed = 4'd0;
			8'd2, 8'd9:  r.speed = 4'd2;
			8'd3, 8'd8:  r.speed = 4'd3;
			8'd4, 8'd7:  r.speed = 4'd4;
			default:     r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

>>> sv/remote_drive_controller_top.sv
// Top level of the remote drive controller: command latch, drive rules and PWM.
`timescale 1ns / 1ps
`include "remote_drive_controller_top_macros.svh"
// Two-motor drive controller.
// Input channel (in_valid / in_stall): one beat is either a timer tick (func = 0)
// or a command packet (func = 1) carrying turn, level and auto bytes, plus the
// two bump sensor levels. Output channel (out_valid / out_stall): exactly one
// result beat per input beat, holding bridge pins, buzzer, PWM pins and both
// speed settings as they stand after that beat.
// Throughput: one beat per cycle while the receiver does not stall; the input
// register feeds a single pass of drive-rule logic straight into the result
// register and the state registers. When the receiver stalls, the result
// register holds and the input register still takes one more beat if it is
// empty; after that in_stall rises until the output drains. Configuration:
// pwm_period at byte address 0, turn_boost at 4, on the APB port; the user must
// write them only while the block is idle, unenforced; pready is always high.
// Reset: speeds 0, level command 5 (stop), buzzer flag and both PWM flags high,
// PWM period 11, turn boost 2, both channels empty.
module remote_drive_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  turn_byte,
	input  logic [7:0]  level_byte,
	input  logic [7:0]  auto_byte,
	input  logic        front_clear,
	input  logic        rear_clear,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        left_a_drive,
	output logic        left_b_drive,
	output logic        right_a_drive,
	output logic        right_b_drive,
	output logic        buzzer_off,
	output logic        left_pulse,
	output logic        right_pulse,
	output logic [3:0]  left_level_now,
	output logic [3:0]  right_level_now
);
	import rdc_pkg::*;

	// configuration
	logic [3:0] pwm_period_q;
	logic [2:0] turn_boost_q;

	// input register
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] turn_s1;
	logic [7:0] level_s1;
	logic [7:0] auto_s1;
	logic       front_s1;
	logic       rear_s1;

	// drive state
	logic [7:0] turn_cmd_q, level_cmd_q, auto_cmd_q;
	logic [3:0] left_speed_q, right_speed_q, pwm_cnt_q;
	logic       turn_l_q, turn_r_q, turn_hold_q;
	logic       fwd_q, rev_q;
	bridge_t    bridge_q;
	logic       buzzer_q;
	logic       pulse_l_q, pulse_r_q;

	// next state
	logic [7:0] turn_n, level_n, auto_n;
	logic [3:0] ls_n, rs_n, cnt_n;
	logic       tl_n, tr_n, hold_n, fwd_n, rev_n, buz_n, pl_n, pr_n;
	bridge_t    bridge_n;
	speed_lut_t lut;
	logic [4:0] boost_sum;
	logic [4:0] cnt_inc;

	logic advance;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_PWM_PERIOD: prdata = {28'd0, pwm_period_q};
			REG_TURN_BOOST: prdata = {29'd0, turn_boost_q};
			default:        prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_period_q <= RESET_PERIOD;
			turn_boost_q <= RESET_BOOST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_PWM_PERIOD: pwm_period_q <= pwdata[3:0];
				REG_TURN_BOOST: turn_boost_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// handshake: s1 moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1  <= func;
			turn_s1  <= turn_byte;
			level_s1 <= level_byte;
			auto_s1  <= auto_byte;
			front_s1 <= front_clear;
			rear_s1  <= rear_clear;
		end
	end

	// drive rules for the beat in s1
	always_comb begin
		turn_n  = func_s1 ? turn_s1  : turn_cmd_q;
		level_n = func_s1 ? level_s1 : level_cmd_q;
		auto_n  = func_s1 ? auto_s1  : auto_cmd_q;

		ls_n     = left_speed_q;
		rs_n     = right_speed_q;
		tl_n     = turn_l_q;
		tr_n     = turn_r_q;
		hold_n   = turn_hold_q;
		fwd_n    = fwd_q;
		rev_n    = rev_q;
		bridge_n = bridge_q;
		buz_n    = buzzer_q;
		lut      = speed_lookup(level_n);
		boost_sum = 5'd0;

		if (auto_n == 8'd0) begin
			fwd_n = 1'b0;
			rev_n = 1'b0;
			if (!turn_hold_q && lut.hit) begin
				ls_n = lut.speed;
				rs_n = lut.speed;
			end
			if (turn_n == TURN_LEFT) begin
				if (!turn_l_q) begin
					boost_sum = {1'b0, ls_n} + {2'b00, turn_boost_q};
					ls_n   = (boost_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : boost_sum[3:0];
					tl_n   = 1'b1;
					hold_n = 1'b1;
				end
			end else if (turn_n == TURN_RIGHT) begin
				if (!turn_r_q) begin
					boost_sum = {1'b0, rs_n} + {2'b00, turn_boost_q};
					rs_n   = (boost_sum > {1'b0, SPEED_MAX}) ? SPEED_MAX : boost_sum[3:0];
					tr_n   = 1'b1;
					hold_n = 1'b1;
				end
			end else begin
				tl_n   = 1'b0;
				tr_n   = 1'b0;
				hold_n = 1'b0;
				if (ls_n < rs_n) rs_n = ls_n;
				else ls_n = rs_n;
			end
			if (level_n > LEVEL_STOP_HI) begin
				if (!front_s1) begin
					bridge_n.lb = 1'b0;
					bridge_n.rb = 1'b0;
					buz_n = 1'b0;
				end else begin
					bridge_n = '{la: 1'b0, lb: 1'b1, ra: 1'b0, rb: 1'b1};
					buz_n = 1'b1;
				end
			end else if (level_n < LEVEL_STOP_LO) begin
				if (!rear_s1) begin
					bridge_n.la = 1'b0;
					bridge_n.ra = 1'b0;
					buz_n = 1'b0;
				end else begin
					bridge_n = '{la: 1'b1, lb: 1'b0, ra: 1'b1, rb: 1'b0};
					buz_n = 1'b1;
				end
			end else begin
				bridge_n = '{la: 1'b0, lb: 1'b0, ra: 1'b0, rb: 1'b0};
				buz_n = 1'b1;
			end
		end else begin
			// bounce between the bumpers
			if (!front_s1 && !fwd_q) begin
				fwd_n = 1'b1;
				rev_n = 1'b0;
				bridge_n = '{la: 1'b1, lb: 1'b0, ra: 1'b1, rb: 1'b0};
			end else if (!rear_s1 && !rev_q) begin
				rev_n = 1'b1;
				fwd_n = 1'b0;
				bridge_n = '{la: 1'b0, lb: 1'b1, ra: 1'b0, rb: 1'b1};
			end
			ls_n = AUTO_SPEED;
			rs_n = AUTO_SPEED;
		end

		// PWM step on ticks only
		pl_n    = pulse_l_q;
		pr_n    = pulse_r_q;
		cnt_n   = pwm_cnt_q;
		cnt_inc = {1'b0, pwm_cnt_q} + 5'd1;
		if (!func_s1) begin
			if (pwm_cnt_q >= ls_n) pl_n = 1'b1;
			if (pwm_cnt_q >= rs_n) pr_n = 1'b1;
			cnt_n = cnt_inc[3:0];
			if (cnt_inc >= {1'b0, pwm_period_q}) begin
				cnt_n = 4'd0;
				pl_n  = 1'b0;
				pr_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_cmd_q    <= 8'd0;
			level_cmd_q   <= LEVEL_RESET;
			auto_cmd_q    <= 8'd0;
			left_speed_q  <= 4'd0;
			right_speed_q <= 4'd0;
			pwm_cnt_q     <= 4'd0;
			turn_l_q      <= 1'b0;
			turn_r_q      <= 1'b0;
			turn_hold_q   <= 1'b0;
			fwd_q         <= 1'b0;
			rev_q         <= 1'b0;
			bridge_q      <= '{la: 1'b0, lb: 1'b0, ra: 1'b0, rb: 1'b0};
			buzzer_q      <= 1'b1;
			pulse_l_q     <= 1'b1;
			pulse_r_q     <= 1'b1;
		end else if (advance) begin
			turn_cmd_q    <= turn_n;
			level_cmd_q   <= level_n;
			auto_cmd_q    <= auto_n;
			left_speed_q  <= ls_n;
			right_speed_q <= rs_n;
			pwm_cnt_q     <= cnt_n;
			turn_l_q      <= tl_n;
			turn_r_q      <= tr_n;
			turn_hold_q   <= hold_n;
			fwd_q         <= fwd_n;
			rev_q         <= rev_n;
			bridge_q      <= bridge_n;
			buzzer_q      <= buz_n;
			pulse_l_q     <= pl_n;
			pulse_r_q     <= pr_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_a_drive    <= bridge_n.la;
			left_b_drive    <= bridge_n.lb;
			right_a_drive   <= bridge_n.ra;
			right_b_drive   <= bridge_n.rb;
			buzzer_off      <= buz_n;
			left_pulse      <= pl_n;
			right_pulse     <= pr_n;
			left_level_now  <= ls_n;
			right_level_now <= rs_n;
		end
	end

	`RDC_ASSERT_SAME(a_no_shoot_through, 1'b1, !(bridge_q.la && bridge_q.lb) && !(bridge_q.ra && bridge_q.rb))
	`RDC_ASSERT_SAME(a_hold_has_side, 1'b1, turn_hold_q == (turn_l_q || turn_r_q))
	`RDC_ASSERT_NEXT(a_auto_speed, advance && (auto_n != 8'd0), (left_speed_q == AUTO_SPEED) && (right_speed_q == AUTO_SPEED))
	`RDC_ASSERT_NEXT(a_result_follows, advance, out_valid && (left_level_now == left_speed_q) && (right_level_now == right_speed_q))

endmodule
